// ===== rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared constants and types for the epoch seconds to calendar block
// Holds the reciprocal constants of the fixed divisions, the pipeline depth,
// the per-stage advance struct and the month offset table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

	// Pipeline depth from the input register to the result register.
	localparam int NUM_STG = 7;

	localparam int RAW_W  = 32;
	localparam int DAYS_W = 16;
	localparam int SOD_W  = 17;
	localparam int SOH_W  = 12;
	localparam int DJ_W   = 16;
	localparam int YOE_W  = 8;
	localparam int DOY_W  = 9;
	localparam int MP_W   = 4;

	localparam int SEC_W  = 6;
	localparam int MIN_W  = 6;
	localparam int HOUR_W = 5;
	localparam int DOM_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 12;

	localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [11:0] SECS_PER_MIN  = 12'd60;

	// Days divide: raw / 86400 = (raw >> 7) / 675, exact for 25-bit operands.
	localparam int          DAY_SHIFT = 35;
	localparam logic [25:0] DAY_RECIP = 26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

	// Hour divide: sod / 3600 = (sod >> 4) / 225, exact for 13-bit operands.
	localparam int          HOUR_SHIFT = 21;
	localparam logic [13:0] HOUR_RECIP = 14'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);

	// Minute divide: soh / 60 = (soh >> 2) / 15, exact for 10-bit operands.
	localparam int          MIN_SHIFT = 14;
	localparam logic [10:0] MIN_RECIP = 11'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

	// Four-year cycle divide by 1461, exact for 18-bit operands.
	localparam int          CYC_SHIFT = 29;
	localparam logic [18:0] CYC_RECIP = 19'(((64'd1 << CYC_SHIFT) + 64'd1460) / 64'd1461);

	// Month divide by 153, exact for 11-bit operands.
	localparam int          MP_SHIFT = 19;
	localparam logic [11:0] MP_RECIP = 12'(((64'd1 << MP_SHIFT) + 64'd152) / 64'd153);

	// Day count is rebased to 1968-03-01, the start of a March-based year.
	localparam logic [15:0] DJ_BASE   = 16'd671;
	// First day count that lies on or after 2100-03-01.
	localparam logic [15:0] DAY_2100M = 16'd47541;
	localparam logic [11:0] BASE_YEAR = 12'd1968;

	// Advance enables of the pipeline stages, one bit per stage. The input
	// register stage s1 is the least significant bit.
	typedef struct packed {
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} esc_adv_t;

	// Day-of-year offset of each month in a March-based year.
	function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
		logic [DOY_W-1:0] ofs;
		case (mp)
			4'd0:    ofs = 9'd0;
			4'd1:    ofs = 9'd31;
			4'd2:    ofs = 9'd61;
			4'd3:    ofs = 9'd92;
			4'd4:    ofs = 9'd122;
			4'd5:    ofs = 9'd153;
			4'd6:    ofs = 9'd184;
			4'd7:    ofs = 9'd214;
			4'd8:    ofs = 9'd245;
			4'd9:    ofs = 9'd275;
			4'd10:   ofs = 9'd306;
			4'd11:   ofs = 9'd337;
			default: ofs = 9'd0;
		endcase
		return ofs;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/esc_split.sv =====
// ----------------------------------------------------------------------------
// esc_split: whole days and seconds of day
// Divides the raw seconds by 86400, then forms the second of the day and the
// day count rebased to 1968-03-01 with the missing leap day of 2100 filled in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_split
	import esc_pkg::*;
(
	input  wire logic             clk,
	input  wire esc_adv_t         adv,
	input  wire logic [RAW_W-1:0] raw_s1,
	output logic      [SOD_W-1:0] sod_s3,
	output logic      [DJ_W-1:0]  dj_s3
);

	logic [50:0]       day_prod;
	logic [DAYS_W-1:0] days_s2;
	logic [RAW_W-1:0]  raw_s2;
	logic [31:0]       day_base;
	logic [31:0]       sod_full;

	assign day_prod = 51'(raw_s1[31:7]) * 51'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			days_s2 <= day_prod[DAY_SHIFT +: DAYS_W];
			raw_s2  <= raw_s1;
		end
	end

	assign day_base = 32'(days_s2) * SECS_PER_DAY;
	assign sod_full = raw_s2 - day_base;

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sod_s3 <= sod_full[SOD_W-1:0];
			// Counting in four-year cycles would give 2100 a leap day; skipping
			// one day from March 2100 on keeps the cycle arithmetic exact.
			if (days_s2 >= DAY_2100M) begin
				dj_s3 <= days_s2 + DJ_BASE + 16'd1;
			end else begin
				dj_s3 <= days_s2 + DJ_BASE;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/esc_tod.sv =====
// ----------------------------------------------------------------------------
// esc_tod: time of day
// Splits the second of the day into hour, minute and second over four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_tod
	import esc_pkg::*;
(
	input  wire logic             clk,
	input  wire esc_adv_t         adv,
	input  wire logic [SOD_W-1:0] sod_s3,
	output logic      [SEC_W-1:0]  sec_s7,
	output logic      [MIN_W-1:0]  min_s7,
	output logic      [HOUR_W-1:0] hour_s7
);

	logic [26:0]       hour_prod;
	logic [HOUR_W-1:0] hour_s4, hour_s5, hour_s6;
	logic [SOD_W-1:0]  sod_s4;
	logic [SOD_W-1:0]  soh_full;
	logic [SOH_W-1:0]  soh_s5, soh_s6;
	logic [20:0]       min_prod;
	logic [MIN_W-1:0]  min_s6;
	logic [SOH_W-1:0]  sec_full;

	assign hour_prod = 27'(sod_s3[SOD_W-1:4]) * 27'(HOUR_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			hour_s4 <= hour_prod[HOUR_SHIFT +: HOUR_W];
			sod_s4  <= sod_s3;
		end
	end

	assign soh_full = sod_s4 - SOD_W'(hour_s4) * SECS_PER_HOUR;

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			soh_s5  <= soh_full[SOH_W-1:0];
			hour_s5 <= hour_s4;
		end
	end

	assign min_prod = 21'(soh_s5[SOH_W-1:2]) * 21'(MIN_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			min_s6  <= min_prod[MIN_SHIFT +: MIN_W];
			soh_s6  <= soh_s5;
			hour_s6 <= hour_s5;
		end
	end

	assign sec_full = soh_s6 - SOH_W'(min_s6) * SECS_PER_MIN;

	always_ff @(posedge clk) begin
		if (adv.s7) begin
			sec_s7  <= sec_full[SEC_W-1:0];
			min_s7  <= min_s6;
			hour_s7 <= hour_s6;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/esc_date.sv =====
// ----------------------------------------------------------------------------
// esc_date: calendar date
// Turns the rebased day count into year, month and day of month using
// March-based years and four-year cycles, over four stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module esc_date
	import esc_pkg::*;
(
	input  wire logic            clk,
	input  wire esc_adv_t        adv,
	input  wire logic [DJ_W-1:0] dj_s3,
	output logic      [DOM_W-1:0]  dom_s7,
	output logic      [MON_W-1:0]  month_s7,
	output logic      [YEAR_W-1:0] year_s7
);

	logic [17:0]      cyc_num;
	logic [36:0]      cyc_prod;
	logic [YOE_W-1:0] yoe_s4, yoe_s5, yoe_s6;
	logic [DJ_W-1:0]  dj_s4;
	logic [DJ_W-1:0]  yoe_days;
	logic [DJ_W-1:0]  doy_full;
	logic [DOY_W-1:0] doy_s5, doy_s6;
	logic [10:0]      mp_num;
	logic [22:0]      mp_prod;
	logic [MP_W-1:0]  mp_s6;
	logic [DOY_W-1:0] dom_full;
	logic             past_dec;

	// Year of era is (4 * dj + 3) / 1461.
	assign cyc_num  = {dj_s3, 2'b11};
	assign cyc_prod = 37'(cyc_num) * 37'(CYC_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			yoe_s4 <= cyc_prod[CYC_SHIFT +: YOE_W];
			dj_s4  <= dj_s3;
		end
	end

	assign yoe_days = DJ_W'(yoe_s4) * 16'd365 + DJ_W'(yoe_s4[YOE_W-1:2]);
	assign doy_full = dj_s4 - yoe_days;

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			doy_s5 <= doy_full[DOY_W-1:0];
			yoe_s5 <= yoe_s4;
		end
	end

	// Month index from March is (5 * doy + 2) / 153.
	assign mp_num  = 11'(doy_s5) * 11'd5 + 11'd2;
	assign mp_prod = 23'(mp_num) * 23'(MP_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s6) begin
			mp_s6  <= mp_prod[MP_SHIFT +: MP_W];
			doy_s6 <= doy_s5;
			yoe_s6 <= yoe_s5;
		end
	end

	assign dom_full = doy_s6 - month_start(mp_s6) + 9'd1;
	// January and February belong to the March-based year before.
	assign past_dec = (mp_s6 >= 4'd10);

	always_ff @(posedge clk) begin
		if (adv.s7) begin
			dom_s7 <= dom_full[DOM_W-1:0];
			if (past_dec) begin
				month_s7 <= mp_s6 - 4'd9;
			end else begin
				month_s7 <= mp_s6 + 4'd3;
			end
			year_s7 <= BASE_YEAR + YEAR_W'(yoe_s6) + YEAR_W'(past_dec);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar: seconds since 1970 to Gregorian date and time
// Each item passes through 7 register stages, from the input register to the
// output registers. Throughput: one item per cycle while the consumer keeps
// taking results; the seven-stage pipeline with reciprocal multipliers sets
// this. Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar
	import esc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire logic [RAW_W-1:0]  raw_seconds,

	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output logic      [SEC_W-1:0]  second,
	output logic      [MIN_W-1:0]  minute,
	output logic      [HOUR_W-1:0] hour,
	output logic      [DOM_W-1:0]  day_of_month,
	output logic      [MON_W-1:0]  month,
	output logic      [YEAR_W-1:0] year
);

	// Stage valid bits; the last one marks a result waiting in the output
	// registers. Index 0 is the input register stage.
	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] adv_vec;
	esc_adv_t           adv;

	logic [RAW_W-1:0]   raw_s1;
	logic [SOD_W-1:0]   sod_s3;
	logic [DJ_W-1:0]    dj_s3;

	// A stage loads when it is empty or when its content moves on in the same
	// cycle. This lets bubbles collapse, so an item is taken every cycle as
	// long as the consumer keeps taking results, and the pipeline still fills
	// up behind a stalled output without losing anything.
	always_comb begin
		adv_vec[NUM_STG-1] = !vld_q[NUM_STG-1] || rsp_ready;
		for (int k = NUM_STG - 2; k >= 0; k--) begin
			adv_vec[k] = !vld_q[k] || adv_vec[k+1];
		end
	end

	assign adv = esc_adv_t'(adv_vec[0 +: NUM_STG]);

	assign req_ready = adv.s1;
	assign rsp_valid = vld_q[NUM_STG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv_vec[0]) begin
				vld_q[0] <= req_valid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (adv_vec[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Input register: the timestamp enters the pipeline here.
	always_ff @(posedge clk) begin
		if (adv.s1) begin
			raw_s1 <= raw_seconds;
		end
	end

	// Stages 2 and 3: whole days and the second of the day.
	esc_split u_split (
		.clk    (clk),
		.adv    (adv),
		.raw_s1 (raw_s1),
		.sod_s3 (sod_s3),
		.dj_s3  (dj_s3)
	);

	// Stages 4 to 7, time of day. Its last stage is the output register.
	esc_tod u_tod (
		.clk     (clk),
		.adv     (adv),
		.sod_s3  (sod_s3),
		.sec_s7  (second),
		.min_s7  (minute),
		.hour_s7 (hour)
	);

	// Stages 4 to 7, calendar date, in parallel with the time of day.
	esc_date u_date (
		.clk      (clk),
		.adv      (adv),
		.dj_s3    (dj_s3),
		.dom_s7   (day_of_month),
		.month_s7 (month),
		.year_s7  (year)
	);

	// With the output register empty every stage can move, so the block must
	// be ready for a new item.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input not ready while the pipeline output is empty");

	// Time fields of a presented result stay in their ranges.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (second <= 6'd59) && (minute <= 6'd59) && (hour <= 5'd23))
		else $error("time of day field out of range");

	// Date fields of a presented result stay in their ranges.
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (month >= 4'd1) && (month <= 4'd12) && (day_of_month >= 5'd1)
			&& (year >= 12'd1970) && (year <= 12'd2106))
		else $error("date field out of range");

	// A result that is not taken stays presented with all its fields unchanged.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid
			&& $stable({second, minute, hour, day_of_month, month, year}))
		else $error("result changed or dropped while stalled");

endmodule

`default_nettype wire
